// ===== sv/md5_message_digest_defines.svh =====
// Assertion macros shared by the MD5 block.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// check that a condition implies a consequence in the same cycle
`define MD5_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Constants, tables and control types of the MD5 block.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LEN_LIMIT = 55;
    localparam int unsigned COUNT_W = 61;

    // datapath commands
    typedef struct packed {
        logic wr_byte;     // store input byte and count
        logic load_w;      // copy block store into word buffer
        logic pad_first;   // build first pad block (1) vs plain
        logic pad_second;  // build second pad block
        logic start_rnd;   // latch chaining words into a..d
        logic do_rnd;      // one round
        logic add_back;    // add a..d into chaining words
        logic reset_chain; // restore IV and clear count
    } md5_cmd_t;

    typedef struct packed {
        logic block_full;  // count wrapped to a block boundary on this byte
        logic two_blocks;  // padding needs two blocks
        logic last_rnd;    // round 63 in progress
    } md5_sts_t;

    function automatic logic [31:0] sine_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== sv/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// md5_datapath
// Block store, word buffer, round unit and chaining words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_datapath
    import md5_pkg::*;
#(
    parameter int unsigned CNT_W = COUNT_W
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire md5_cmd_t      cmd,
    input  wire logic [7:0]    data_byte,
    output md5_sts_t           sts,
    output logic [63:0]        dig_lo,
    output logic [63:0]        dig_hi
);
    logic [7:0]       store_reg [64];
    logic [511:0]     w_reg;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg;
    logic [31:0]      h0_reg, h1_reg, h2_reg, h3_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [5:0]       rnd_reg;
    logic [5:0]       rem;
    logic [63:0]      bits;
    logic [511:0]     blk;
    logic [31:0]      f, t, rot, wsel;
    logic [3:0]       idx;

    assign rem  = cnt_reg[5:0];
    assign bits = 64'({cnt_reg, 3'b000});
    // the controller qualifies this with the byte flag of the item
    assign sts.block_full = (rem == 6'd63);
    assign sts.two_blocks = (32'(rem) > LEN_LIMIT);
    assign sts.last_rnd   = (rnd_reg == 6'd63);

    // stored bytes, or padded: bytes below rem, pad marker, zeros, length
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            if (!cmd.pad_first && !cmd.pad_second)
                blk[8*i +: 8] = store_reg[i];
            else if (cmd.pad_first && (6'(i) < rem))
                blk[8*i +: 8] = store_reg[i];
            else if (cmd.pad_first && (6'(i) == rem))
                blk[8*i +: 8] = PAD_BYTE;
            else
                blk[8*i +: 8] = 8'h00;
        end
        if ((cmd.pad_first && !sts.two_blocks) || cmd.pad_second)
            blk[511:448] = bits;
    end

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    begin f = (b_reg & c_reg) | (~b_reg & d_reg); idx = rnd_reg[3:0]; end
            2'd1:    begin f = (d_reg & b_reg) | (~d_reg & c_reg);
                           idx = 4'(5 * rnd_reg + 1); end
            2'd2:    begin f = b_reg ^ c_reg ^ d_reg; idx = 4'(3 * rnd_reg + 5); end
            default: begin f = c_reg ^ (b_reg | ~d_reg); idx = 4'(7 * rnd_reg); end
        endcase
        wsel = w_reg[32*idx +: 32];
        t    = f + a_reg + sine_k(rnd_reg) + wsel;
        rot  = (t << rot_s(rnd_reg)) | (t >> (6'd32 - {1'b0, rot_s(rnd_reg)}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
            store_reg[rem] <= data_byte;
        if (cmd.load_w)
            w_reg <= blk;
        if (cmd.start_rnd)
        begin
            a_reg <= h0_reg; b_reg <= h1_reg; c_reg <= h2_reg; d_reg <= h3_reg;
        end
        else if (cmd.do_rnd)
        begin
            a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= b_reg + rot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg <= IV0; h1_reg <= IV1; h2_reg <= IV2; h3_reg <= IV3;
            cnt_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cmd.wr_byte)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.start_rnd)
                rnd_reg <= '0;
            else if (cmd.do_rnd)
                rnd_reg <= rnd_reg + 1'b1;
            if (cmd.reset_chain)
            begin
                h0_reg <= IV0; h1_reg <= IV1; h2_reg <= IV2; h3_reg <= IV3;
                cnt_reg <= '0;
            end
            else if (cmd.add_back)
            begin
                h0_reg <= h0_reg + a_reg; h1_reg <= h1_reg + b_reg;
                h2_reg <= h2_reg + c_reg; h3_reg <= h3_reg + d_reg;
            end
        end
    end

    assign dig_lo = {h1_reg, h0_reg};
    assign dig_hi = {h3_reg, h2_reg};

    `MD5_ASSERT_IMPL(a_rnd_excl, clk, rst_n, cmd.do_rnd, !cmd.start_rnd)
    `MD5_ASSERT_NEXT(a_rnd_adv, clk, rst_n, cmd.do_rnd && !sts.last_rnd,
        rnd_reg == $past(rnd_reg) + 6'd1)
    `MD5_ASSERT_NEXT(a_cnt_clr, clk, rst_n, cmd.reset_chain, cnt_reg == '0)
endmodule
`default_nettype wire

// ===== sv/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, block loads, 64 rounds, padding and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic byte_valid,
    input  wire logic end_of_message,
    input  wire md5_sts_t sts,
    output md5_cmd_t  cmd,
    input  wire logic out_ready,
    output logic      out_valid,
    output logic      out_sel
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_START = 9'b000000100,
        S_RND   = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_OUT0  = 9'b000100000,
        S_OUT1  = 9'b001000000,
        S_PAD1  = 9'b010000000,
        S_PAD2  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    // phase: 0 data block, 1 first pad block, 2 second pad block
    logic [1:0] ph_reg, ph_next;
    logic       eom_reg, eom_next;
    logic       acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign out_sel   = (state_reg == S_OUT1);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        eom_next   = eom_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.wr_byte = byte_valid;
                    eom_next    = end_of_message;
                    if (byte_valid && sts.block_full)
                    begin
                        ph_next = 2'd0; state_next = S_LOAD;
                    end
                    else if (end_of_message)
                        state_next = S_PAD1;
                end
            end
            S_LOAD:  begin cmd.load_w = 1'b1; state_next = S_START; end
            S_PAD1:
            begin
                cmd.load_w = 1'b1; cmd.pad_first = 1'b1;
                ph_next = 2'd1; state_next = S_START;
            end
            S_PAD2:
            begin
                cmd.load_w = 1'b1; cmd.pad_second = 1'b1;
                ph_next = 2'd2; state_next = S_START;
            end
            S_START: begin cmd.start_rnd = 1'b1; state_next = S_RND; end
            S_RND:
            begin
                cmd.do_rnd = 1'b1;
                if (sts.last_rnd)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_back = 1'b1;
                if (ph_reg == 2'd0)
                    state_next = eom_reg ? S_PAD1 : S_IDLE;
                else if (ph_reg == 2'd1 && sts.two_blocks)
                    state_next = S_PAD2;
                else
                    state_next = S_OUT0;
            end
            S_OUT0:  if (out_ready) state_next = S_OUT1;
            S_OUT1:
            begin
                if (out_ready)
                begin
                    cmd.reset_chain = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; ph_reg <= 2'd0; eom_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; ph_reg <= ph_next; eom_reg <= eom_next;
        end
    end

    `MD5_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && out_sel == $past(out_sel))
    `MD5_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `MD5_ASSERT_NEXT(a_second, clk, rst_n, state_reg == S_OUT0 && out_ready, out_sel)
endmodule
`default_nettype wire

// ===== sv/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries data_byte, byte_valid and
// end_of_message. Output channel out_valid/out_ready carries digest_half and
// final_half: two items per message, bytes 0-7 then bytes 8-15.
// A byte that does not complete a 64-byte block leaves intake ready. A byte
// that completes a block holds intake while the block is processed (load,
// latch, 64 rounds on the single round unit, add back). An end-of-message
// item runs one or two padding blocks the same way, then both digest items.
// Reset loads the initial vector and clears the byte count; the block store
// holds no reset value. When the receiver stalls, the digest items hold and
// no new input item is taken until both are delivered.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_message_digest
    import md5_pkg::*;
#(
    parameter int unsigned CNT_W = COUNT_W
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      digest_half,
    output logic             final_half
);
    md5_cmd_t    cmd;
    md5_sts_t    sts;
    logic [63:0] dig_lo, dig_hi;
    logic        out_sel;

    md5_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .byte_valid(byte_valid), .end_of_message(end_of_message), .sts(sts),
        .cmd(cmd), .out_ready(out_ready), .out_valid(out_valid), .out_sel(out_sel)
    );

    md5_datapath #(.CNT_W(CNT_W)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(data_byte), .sts(sts),
        .dig_lo(dig_lo), .dig_hi(dig_hi)
    );

    assign digest_half = out_sel ? dig_hi : dig_lo;
    assign final_half  = out_sel;
endmodule
`default_nettype wire
